>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

>>> hdl/lfr_pkg.sv
`timescale 1ns / 1ps

package lfr_pkg;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int CHAN_W   = 2;
    localparam int VALUE_W  = 16;
    localparam int REG_W    = 16;
    localparam int SERIAL_W = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_RAW  = 2'd1;
    localparam logic [OP_W-1:0] OP_RGB  = 2'd2;

    localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STS_NO_SERIAL = 3'd1;
    localparam logic [STATUS_W-1:0] STS_NO_CAL    = 3'd2;
    localparam logic [STATUS_W-1:0] STS_UNDER     = 3'd3;
    localparam logic [STATUS_W-1:0] STS_OVER      = 3'd4;

    localparam logic [CHAN_W-1:0] CH_RED   = 2'd0;
    localparam logic [CHAN_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CHAN_W-1:0] CH_BLUE  = 2'd2;
    localparam logic [CHAN_W-1:0] CH_RAW   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRE_SCALE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_RED      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_GREEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_BLUE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SERIAL        = 3'd5;

    localparam logic [REG_W-1:0]    IT_NO_SCALE  = 16'hffff;
    localparam logic [REG_W-1:0]    DARK_UNCAL   = 16'hffff;
    localparam logic [VALUE_W-1:0]  VALUE_MAX    = 16'h7fff;
    localparam logic [SERIAL_W-1:0] SERIAL_BLANK = 32'hffff_ffff;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAS,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_RES,
        ST_ERR
    } t_state;

    typedef struct packed {
        logic start;
        logic start_rgb;
        logic sample;
        logic mul;
        logic div_start;
        logic emit;
        logic emit_chk;
    } t_cmd;

    typedef struct packed {
        logic window_end;
        logic chk_fail;
        logic it_full;
        logic it_zero;
        logic div_done;
        logic out_free;
        logic res_last;
    } t_stat;

endpackage

>>> hdl/lfr_div.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lfr_pkg::REG_W-1:0]   i_count,
    input  logic [lfr_pkg::REG_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [lfr_pkg::VALUE_W-1:0] o_quotient
);
    import lfr_pkg::*;

    localparam int DIV_STEPS = 2 * REG_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_STEPS-1:0] r_dividend;
    logic [REG_W-1:0]     r_rem;
    logic [VALUE_W-1:0]   r_quo;

    logic [REG_W:0] trial;
    logic [REG_W:0] diff;
    logic           ge;
    logic [REG_W-1:0] n_rem;

    assign trial = {r_rem, r_dividend[DIV_STEPS-1]};
    assign diff  = trial - {1'b0, i_divisor};
    assign ge    = trial >= {1'b0, i_divisor};
    assign n_rem = ge ? diff[REG_W-1:0] : trial[REG_W-1:0];

    assign o_done     = r_busy && (r_cnt == LAST_STEP);
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dividend <= {i_count, {REG_W{1'b0}}} - {{REG_W{1'b0}}, i_count};
            r_rem      <= '0;
            r_quo      <= '0;
        end else if (r_busy) begin
            r_dividend <= {r_dividend[DIV_STEPS-2:0], 1'b0};
            r_rem      <= n_rem;
            r_quo      <= {r_quo[VALUE_W-2:0], ge};
        end
    end

    `ASSERT_CLK(a_div_start_busy, i_clk, i_rst_n, i_start |=> r_busy, "divider did not start")
    `ASSERT_NEVER(a_div_restart, i_clk, i_rst_n, i_start && r_busy, "divider restarted while busy")

endmodule

>>> hdl/lfr_dp.sv
`timescale 1ns / 1ps

module lfr_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lfr_pkg::t_cmd                 i_cmd,
    output lfr_pkg::t_stat                o_stat,
    input  logic                          i_level,
    input  logic                          i_cfg_we,
    input  logic [lfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lfr_pkg::SERIAL_W-1:0]  i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lfr_pkg::STATUS_W-1:0]  o_status,
    output logic [lfr_pkg::CHAN_W-1:0]    o_channel,
    output logic [lfr_pkg::VALUE_W-1:0]   o_value,
    output logic                          o_last
);
    import lfr_pkg::*;

    logic [REG_W-1:0]    r_integral_time;
    logic [REG_W-1:0]    r_pre_scale;
    logic [REG_W-1:0]    r_dark_red;
    logic [REG_W-1:0]    r_dark_green;
    logic [REG_W-1:0]    r_dark_blue;
    logic [SERIAL_W-1:0] r_serial;

    logic              r_ref;
    logic [REG_W-1:0]  r_edges;
    logic [REG_W-1:0]  r_samples;
    logic              r_rgb;
    logic [CHAN_W-1:0] r_channel;
    logic [REG_W-1:0]  r_count;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [CHAN_W-1:0]   r_out_channel;
    logic [VALUE_W-1:0]  r_value;
    logic                r_last;

    logic                  sd_lt;
    logic [REG_W-1:0]      n_samples;
    logic [2*REG_W-1:0]    product;
    logic                  div_done;
    logic [VALUE_W-1:0]    quotient;
    logic [VALUE_W-1:0]    reading;
    logic [REG_W-1:0]      dark;
    logic [STATUS_W-1:0]   res_status;
    logic [CHAN_W-1:0]     res_channel;
    logic [VALUE_W-1:0]    res_value;
    logic                  res_last;

    assign sd_lt     = r_samples < r_integral_time;
    assign n_samples = sd_lt ? r_samples + 1'b1 : r_samples;
    assign product   = {{REG_W{1'b0}}, r_edges} * {{REG_W{1'b0}}, r_pre_scale};

    lfr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_count    (r_count),
        .i_divisor  (r_integral_time),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_comb begin
        if (r_integral_time == IT_NO_SCALE) begin
            reading = r_count;
        end else if (r_integral_time == '0) begin
            reading = '0;
        end else begin
            reading = quotient;
        end
    end

    always_comb begin
        unique case (r_channel)
            CH_RED:   dark = r_dark_red;
            CH_GREEN: dark = r_dark_green;
            default:  dark = r_dark_blue;
        endcase
    end

    always_comb begin
        res_status  = STS_OK;
        res_channel = r_channel;
        res_value   = '0;
        res_last    = 1'b1;
        if (!r_rgb) begin
            res_channel = CH_RAW;
            res_value   = reading;
        end else if (reading < dark) begin
            res_status = STS_UNDER;
        end else if (reading > VALUE_MAX) begin
            res_status = STS_OVER;
        end else if (r_channel >= CH_BLUE) begin
            res_channel = CH_BLUE;
            res_value   = reading - dark;
        end else begin
            res_value = reading - dark;
            res_last  = 1'b0;
        end
    end

    always_comb begin
        o_stat.window_end = !(n_samples < r_integral_time);
        o_stat.chk_fail   = (r_serial == SERIAL_BLANK) || (r_dark_red == DARK_UNCAL);
        o_stat.it_full    = r_integral_time == IT_NO_SCALE;
        o_stat.it_zero    = r_integral_time == '0;
        o_stat.div_done   = div_done;
        o_stat.out_free   = !r_out_valid || i_out_ready;
        o_stat.res_last   = res_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral_time <= IT_NO_SCALE;
            r_pre_scale     <= '0;
            r_dark_red      <= '0;
            r_dark_green    <= '0;
            r_dark_blue     <= '0;
            r_serial        <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_INTEGRAL_TIME: r_integral_time <= i_cfg_data[REG_W-1:0];
                REG_PRE_SCALE:     r_pre_scale     <= i_cfg_data[REG_W-1:0];
                REG_DARK_RED:      r_dark_red      <= i_cfg_data[REG_W-1:0];
                REG_DARK_GREEN:    r_dark_green    <= i_cfg_data[REG_W-1:0];
                REG_DARK_BLUE:     r_dark_blue     <= i_cfg_data[REG_W-1:0];
                REG_SERIAL:        r_serial        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref     <= 1'b0;
            r_edges   <= '0;
            r_samples <= '0;
            r_rgb     <= 1'b0;
            r_channel <= CH_RED;
        end else if (i_cmd.start) begin
            r_rgb     <= i_cmd.start_rgb;
            r_channel <= CH_RED;
            r_ref     <= i_level;
            r_edges   <= '0;
            r_samples <= '0;
        end else if (i_cmd.sample && sd_lt) begin
            if (i_level != r_ref) begin
                r_edges <= r_edges + 1'b1;
                r_ref   <= i_level;
            end
            r_samples <= n_samples;
        end else if (i_cmd.emit && !res_last) begin
            r_channel <= r_channel + 1'b1;
            r_edges   <= '0;
            r_samples <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_count <= product[REG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_chk) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status      <= res_status;
            r_out_channel <= res_channel;
            r_value       <= res_value;
            r_last        <= res_last;
        end else if (i_cmd.emit_chk) begin
            r_status      <= (r_serial == SERIAL_BLANK) ? STS_NO_SERIAL : STS_NO_CAL;
            r_out_channel <= CH_RED;
            r_value       <= '0;
            r_last        <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_channel   = r_out_channel;
    assign o_value     = r_value;
    assign o_last      = r_last;

endmodule

>>> hdl/lfr_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfr_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [lfr_pkg::OP_W-1:0] i_op,
    output lfr_pkg::t_cmd            o_cmd,
    input  lfr_pkg::t_stat           i_stat
);
    import lfr_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   need_div;

    assign o_ready  = (r_state == ST_IDLE) || (r_state == ST_MEAS);
    assign accept   = i_valid && o_ready;
    assign need_div = !i_stat.it_full && !i_stat.it_zero;

    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            ST_IDLE, ST_MEAS: begin
                if (accept) begin
                    unique case (i_op)
                        OP_RAW:  n_state = ST_MEAS;
                        OP_RGB:  n_state = i_stat.chk_fail ? ST_ERR : ST_MEAS;
                        OP_TICK: begin
                            if (r_state == ST_MEAS && i_stat.window_end) begin
                                n_state = ST_MUL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: n_state = ST_CHK;
            ST_CHK: n_state = need_div ? ST_DIV : ST_RES;
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_RES;
                end
            end
            ST_RES: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.res_last ? ST_IDLE : ST_MEAS;
                end
            end
            ST_ERR: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state) inside
            ST_IDLE, ST_MEAS: begin
                if (accept) begin
                    unique case (i_op)
                        OP_RAW:  o_cmd.start = 1'b1;
                        OP_RGB: begin
                            o_cmd.start     = 1'b1;
                            o_cmd.start_rgb = 1'b1;
                        end
                        OP_TICK: o_cmd.sample = r_state == ST_MEAS;
                        default: ;
                    endcase
                end
            end
            ST_MUL: o_cmd.mul = 1'b1;
            ST_CHK: o_cmd.div_start = need_div;
            ST_DIV: ;
            ST_RES: o_cmd.emit = i_stat.out_free;
            ST_ERR: o_cmd.emit_chk = i_stat.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_CLK(a_cmd_onehot, i_clk, i_rst_n, $onehot0({o_cmd.start, o_cmd.sample, o_cmd.mul, o_cmd.div_start, o_cmd.emit, o_cmd.emit_chk}), "conflicting datapath commands")
    `ASSERT_CLK(a_div_entry, i_clk, i_rst_n, o_cmd.div_start |=> (r_state == ST_DIV), "divide started outside divide state")
    `ASSERT_CLK(a_res_exit, i_clk, i_rst_n, o_cmd.emit |=> (r_state == ST_IDLE || r_state == ST_MEAS), "result state did not exit after emit")

endmodule

>>> hdl/light_frequency_rgb_reader.sv
// Ticks are taken one per cycle while a window runs; a tick that ends the window stalls input.
// A window-ending tick goes through multiply, check, divide (skipped with integral_time 0 or 0xffff)
// and result states; the 32-step divider gives one bit per cycle. Check errors use the error state.
// Results wait in an output register; ticks keep being taken while one waits.
// Synchronous active-low reset: idle, counters cleared, integral_time 0xffff, other config regs 0.
`timescale 1ns / 1ps

module light_frequency_rgb_reader (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [0] sensor_level
    input  logic [lfr_pkg::OP_W-1:0]          s_axis_tuser,  // [1:0] operation
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [23:0]                       m_axis_tdata,  // [2:0] status, [18:3] value
    output logic [lfr_pkg::CHAN_W-1:0]        m_axis_tuser,  // [1:0] channel
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lfr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lfr_pkg::SERIAL_W-1:0]      i_cfg_data
);
    import lfr_pkg::*;

    t_cmd                cmd;
    t_stat               stat;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;

    assign o_cfg_ready = 1'b1;

    lfr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tuser),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    lfr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_level     (s_axis_tdata[0]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (status),
        .o_channel   (m_axis_tuser),
        .o_value     (value),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b0, value, status};

endmodule
